/* rtl/sasdg_pkg.sv */
package sasdg_pkg;

   // Number of axes and width of the output pin bank.
   localparam int AXES = 6;
   localparam int PIN_BITS = 16;

   // Width of one pin map field and of a whole map.
   localparam int PIN_SEL_BITS = 4;
   localparam int MAP_BITS = AXES * PIN_SEL_BITS;

   // Request kinds carried in the req_type field.
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_TARGET = 1'b1;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      REG_STEP_INTERVAL,
      REG_ESTOP_PAUSE,
      REG_STEP_PIN_MAP,
      REG_DIR_PIN_MAP
   } reg_index_type;

   // Reset values of the configuration registers.
   localparam logic [15:0] STEP_INTERVAL_RESET = 16'd20;
   localparam logic [MAP_BITS-1:0] STEP_PIN_MAP_RESET = 24'hDCBA98;
   localparam logic [MAP_BITS-1:0] DIR_PIN_MAP_RESET = 24'h543210;

   // One input request.
   typedef struct packed {
      logic req_type;
      logic [2:0] axis_sel;
      logic signed [31:0] target_pos;
   } step_req_type;

   // One result.
   typedef struct packed {
      logic [PIN_BITS-1:0] pin_word;
      logic [AXES-1:0] moving_axes;
   } step_rsp_type;

   // Control from the top level to one axis.
   typedef struct packed {
      logic wr_en;
      logic step_en;
   } axis_ctrl_type;

   // Status from one axis to the top level.
   typedef struct packed {
      logic move;
      logic up;
   } axis_status_type;

   // One-hot mask of a pin number; every 4-bit number selects one pin of the 16-pin bank.
   function automatic logic [PIN_BITS-1:0] pin_mask(input logic [PIN_SEL_BITS-1:0] pin);
      logic [PIN_BITS-1:0] mask;
      mask = '0;
      for (int b = 0; b < PIN_BITS; b++) begin
         mask[b] = (pin == PIN_SEL_BITS'(b));
      end
      return mask;
   endfunction

endpackage

/* rtl/sasdg_axis.sv */
module sasdg_axis (
   input  logic                       clock,
   input  logic                       reset,
   input  sasdg_pkg::axis_ctrl_type   ctrl,
   input  logic signed [31:0]         target_value,
   output sasdg_pkg::axis_status_type status
);
   import sasdg_pkg::*;

   logic signed [31:0] target_ff;
   logic signed [31:0] target_in;
   logic signed [31:0] position_ff;
   logic signed [31:0] position_in;

   // Compare target with position; the signed compare picks the direction.
   assign status.move = (target_ff != position_ff);
   assign status.up = (target_ff > position_ff);

   // A step moves the position one count toward the target.
   always_comb begin
      target_in = ctrl.wr_en ? target_value : target_ff;
      position_in = position_ff;
      if (ctrl.step_en && status.move) begin
         position_in = status.up ? position_ff + 32'sd1 : position_ff - 32'sd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         position_ff <= '0;
      end else begin
         target_ff <= target_in;
         position_ff <= position_in;
      end
   end

endmodule

/* rtl/six_axis_step_dir_generator.sv */
// Six-axis step/direction generator. A request is either a one-microsecond
// tick or a new target position for one axis. Ticks advance an elapsed counter
// that saturates at 65535; when it reaches step_interval (0 fires on every
// tick) it restarts, and unless estop_pause is set every axis that is away from
// its target drives its direction pin, pulses its step pin and moves one count
// toward the target. Each such interval yields one result: the pin word with
// the step pulses, and a mask of the axes that stepped. Step pins are cleared
// after each result and direction pins hold. Target writes, paused intervals
// and ticks that do not end an interval yield nothing. The block takes one
// request per clock unless the skid stage is full; all six axes compare and
// step in parallel as the request is taken, and the result is registered at
// that same edge into the output register, or into the skid stage while the
// output register holds a result that waits; so requests keep flowing meanwhile.
// Configuration registers sit at byte offsets 0x0 (step_interval), 0x4
// (estop_pause), 0x8 (step_pin_map) and 0xC (dir_pin_map), and are meant to be
// written only while the block is idle.
module six_axis_step_dir_generator (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  sasdg_pkg::step_req_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output sasdg_pkg::step_rsp_type rsp_data,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [3:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import sasdg_pkg::*;

   // Configuration registers.
   logic [15:0]         step_interval_ff;
   logic                estop_pause_ff;
   logic [MAP_BITS-1:0] step_pin_map_ff;
   logic [MAP_BITS-1:0] dir_pin_map_ff;
   logic                csr_write;
   reg_index_type       csr_index;

   // Timing and pin state.
   logic [15:0]         elapsed_ff;
   logic [15:0]         elapsed_in;
   logic [15:0]         elapsed_inc;
   logic [PIN_BITS-1:0] pin_latch_ff;
   logic [PIN_BITS-1:0] pin_latch_in;
   logic [PIN_BITS-1:0] latch_set;
   logic [PIN_BITS-1:0] step_clear;
   logic [AXES-1:0]     moving;

   // Output register and skid stage.
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   step_rsp_type        rsp_data_ff;
   step_rsp_type        rsp_data_in;
   logic                skid_valid_ff;
   logic                skid_valid_in;
   step_rsp_type        skid_data_ff;
   step_rsp_type        skid_data_in;

   logic                accept;
   logic                is_tick;
   logic                fire;
   logic                step_go;
   logic                rsp_pop;
   step_rsp_type        result;

   axis_ctrl_type       axis_ctrl [AXES];
   axis_status_type     axis_status [AXES];

   // Configuration port: always ready, reads return the register values.
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[3:2]);

   always_comb begin
      unique case (csr_index)
         REG_STEP_INTERVAL: prdata = 32'(step_interval_ff);
         REG_ESTOP_PAUSE:   prdata = 32'(estop_pause_ff);
         REG_STEP_PIN_MAP:  prdata = 32'(step_pin_map_ff);
         REG_DIR_PIN_MAP:   prdata = 32'(dir_pin_map_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_interval_ff <= STEP_INTERVAL_RESET;
         estop_pause_ff <= 1'b0;
         step_pin_map_ff <= STEP_PIN_MAP_RESET;
         dir_pin_map_ff <= DIR_PIN_MAP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_STEP_INTERVAL: step_interval_ff <= pwdata[15:0];
            REG_ESTOP_PAUSE:   estop_pause_ff <= pwdata[0];
            REG_STEP_PIN_MAP:  step_pin_map_ff <= pwdata[MAP_BITS-1:0];
            REG_DIR_PIN_MAP:   dir_pin_map_ff <= pwdata[MAP_BITS-1:0];
            default:           ;
         endcase
      end
   end

   // Request handshake; only a full skid stage holds off new requests.
   assign req_stall = skid_valid_ff;
   assign accept = req_valid && !skid_valid_ff;
   assign is_tick = accept && (req_data.req_type == REQ_TICK);

   // Interval timing: saturating count, compared against the interval.
   assign elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign fire = is_tick && (elapsed_inc >= step_interval_ff);
   assign step_go = fire && !estop_pause_ff;

   always_comb begin
      elapsed_in = elapsed_ff;
      if (is_tick) begin
         elapsed_in = fire ? 16'd0 : elapsed_inc;
      end
   end

   // One instance per axis holds its target and position.
   for (genvar k = 0; k < AXES; k++) begin : g_axis
      assign axis_ctrl[k].wr_en = accept && (req_data.req_type == REQ_TARGET)
                                  && (req_data.axis_sel == 3'(k));
      assign axis_ctrl[k].step_en = step_go;

      sasdg_axis u_axis (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (axis_ctrl[k]),
         .target_value (req_data.target_pos),
         .status       (axis_status[k])
      );
   end

   // Pin word: axes update their pins in order, so a later axis wins a shared pin.
   always_comb begin
      latch_set = pin_latch_ff;
      step_clear = '0;
      for (int k = 0; k < AXES; k++) begin
         moving[k] = axis_status[k].move;
         if (axis_status[k].move) begin
            if (axis_status[k].up) begin
               latch_set = latch_set | pin_mask(dir_pin_map_ff[PIN_SEL_BITS*k +: PIN_SEL_BITS]);
            end else begin
               latch_set = latch_set & ~pin_mask(dir_pin_map_ff[PIN_SEL_BITS*k +: PIN_SEL_BITS]);
            end
            latch_set = latch_set | pin_mask(step_pin_map_ff[PIN_SEL_BITS*k +: PIN_SEL_BITS]);
         end
         step_clear = step_clear | pin_mask(step_pin_map_ff[PIN_SEL_BITS*k +: PIN_SEL_BITS]);
      end
      pin_latch_in = step_go ? (latch_set & ~step_clear) : pin_latch_ff;
      result.pin_word = latch_set;
      result.moving_axes = moving;
   end

   // Output register with skid stage.
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign rsp_pop = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_data_in = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            rsp_valid_in = 1'b1;
            rsp_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (step_go) begin
         if (!rsp_valid_ff || rsp_pop) begin
            rsp_valid_in = 1'b1;
            rsp_data_in = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         pin_latch_ff <= '0;
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         elapsed_ff <= elapsed_in;
         pin_latch_ff <= pin_latch_in;
         rsp_valid_ff <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule
